// File: design/assert_macros.svh
// assertion macros used by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// implication that holds at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: design/sbmq_pkg.sv
// types and codes of the shared buffer multi queue
package sbmq_pkg;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               req_type;
        logic [1:0]         queue_id;
        logic signed [31:0] data_in;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
    } t_res;

    typedef struct packed {
        logic clear;
        logic accept;
        logic fail;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic ok;
    } t_stat;

endpackage

// File: design/sbmq_datapath.sv
// slot store, link memory, queue and free list pointers and result register
`include "assert_macros.svh"

module sbmq_datapath #(
    parameter int SLOT_COUNT  = 16,
    parameter int QUEUE_COUNT = 4,
    parameter int DATA_WIDTH  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sbmq_pkg::t_req i_req,
    input  sbmq_pkg::t_cmd i_cmd,
    output sbmq_pkg::t_stat o_stat,
    output sbmq_pkg::t_res  o_res
);

    localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LW  = $clog2(SLOT_COUNT + 1);
    localparam int QN  = (QUEUE_COUNT < 4) ? QUEUE_COUNT : 4;
    localparam int QIW = (QN > 1) ? $clog2(QN) : 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(SLOT_COUNT);

    logic [LW-1:0]         link_mem [SLOT_COUNT];
    logic [DATA_WIDTH-1:0] data_mem [SLOT_COUNT];

    logic [LW-1:0] r_qhead [QN];
    logic [LW-1:0] r_qtail [QN];
    logic [LW-1:0] n_qhead [QN];
    logic [LW-1:0] n_qtail [QN];
    logic [LW-1:0] r_free_head, n_free_head;
    logic [LW-1:0] r_free_tail, n_free_tail;
    logic [SW-1:0] r_clr;

    logic                  r_op;
    logic [QIW-1:0]        r_qi;
    logic [SW-1:0]         r_slot;
    logic [LW-1:0]         r_link;
    logic [DATA_WIDTH-1:0] r_rdata;
    sbmq_pkg::t_res        r_res;

    logic                   enq;
    logic                   q_ok;
    logic [QIW-1:0]         qi;
    logic [LW-1:0]          head_in;
    logic [SW-1:0]          slot_in;
    logic [DATA_WIDTH+31:0] din_ext;
    logic [DATA_WIDTH+31:0] dout_ext;

    logic          link_ok;
    logic [LW-1:0] link_n;
    logic [LW-1:0] cur_head;
    logic [LW-1:0] cur_tail;
    logic          lk_we;
    logic [SW-1:0] lk_waddr;
    logic [LW-1:0] lk_wdata;

    assign enq      = (i_req.req_type == sbmq_pkg::REQ_ENQ);
    assign q_ok     = (int'(i_req.queue_id) < QUEUE_COUNT);
    assign qi       = QIW'(i_req.queue_id);
    assign head_in  = r_qhead[qi];
    assign slot_in  = enq ? r_free_head[SW-1:0] : head_in[SW-1:0];
    assign din_ext  = {{DATA_WIDTH{1'b0}}, i_req.data_in};
    assign dout_ext = {32'b0, r_rdata};

    assign o_stat.ok = q_ok && (enq ? (r_free_head < NULL_LINK) : (head_in < NULL_LINK));
    assign o_stat.clear_last = (r_clr == SW'(SLOT_COUNT - 1));
    assign o_res = r_res;

    assign link_ok  = (r_link < NULL_LINK);
    assign link_n   = link_ok ? r_link : NULL_LINK;
    assign cur_head = r_qhead[r_qi];
    assign cur_tail = r_qtail[r_qi];

    // link writes of the clear chain and of accept, pointer updates and link write of finish
    always_comb begin
        n_qhead     = r_qhead;
        n_qtail     = r_qtail;
        n_free_head = r_free_head;
        n_free_tail = r_free_tail;
        lk_we       = 1'b0;
        lk_waddr    = slot_in;
        lk_wdata    = NULL_LINK;
        priority if (i_cmd.clear) begin
            lk_we    = 1'b1;
            lk_waddr = r_clr;
            lk_wdata = LW'(r_clr) + LW'(1);
        end else if (i_cmd.accept) begin
            lk_we    = 1'b1;
            lk_waddr = slot_in;
            lk_wdata = NULL_LINK;
        end else if (i_cmd.finish) begin
            lk_wdata = LW'(r_slot);
            if (r_op == sbmq_pkg::REQ_ENQ) begin
                n_free_head = link_n;
                if (!link_ok) begin
                    n_free_tail = NULL_LINK;
                end
                if (cur_head < NULL_LINK && cur_tail < NULL_LINK) begin
                    lk_we         = 1'b1;
                    lk_waddr      = cur_tail[SW-1:0];
                    n_qtail[r_qi] = LW'(r_slot);
                end else begin
                    n_qhead[r_qi] = LW'(r_slot);
                    n_qtail[r_qi] = LW'(r_slot);
                end
            end else begin
                if (LW'(r_slot) == cur_tail) begin
                    n_qhead[r_qi] = NULL_LINK;
                    n_qtail[r_qi] = NULL_LINK;
                end else begin
                    n_qhead[r_qi] = link_n;
                    if (!link_ok) begin
                        n_qtail[r_qi] = NULL_LINK;
                    end
                end
                if (r_free_head < NULL_LINK && r_free_tail < NULL_LINK) begin
                    lk_we       = 1'b1;
                    lk_waddr    = r_free_tail[SW-1:0];
                    n_free_tail = LW'(r_slot);
                end else begin
                    n_free_head = LW'(r_slot);
                    n_free_tail = LW'(r_slot);
                end
            end
        end
    end

    // link memory, read before write
    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            link_mem[lk_waddr] <= lk_wdata;
        end
        if (i_cmd.accept) begin
            r_link <= link_mem[slot_in];
        end
    end

    // slot data memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (enq) begin
                data_mem[slot_in] <= din_ext[DATA_WIDTH-1:0];
            end else begin
                r_rdata <= data_mem[slot_in];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QN; i++) begin
                r_qhead[i] <= NULL_LINK;
                r_qtail[i] <= NULL_LINK;
            end
            r_free_head <= '0;
            r_free_tail <= LW'(SLOT_COUNT - 1);
            r_clr       <= '0;
        end else begin
            r_qhead     <= n_qhead;
            r_qtail     <= n_qtail;
            r_free_head <= n_free_head;
            r_free_tail <= n_free_tail;
            if (i_cmd.clear) begin
                r_clr <= r_clr + SW'(1);
            end
        end
    end

    // request latch and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_req.req_type;
            r_qi   <= qi;
            r_slot <= slot_in;
        end
        if (i_cmd.fail) begin
            r_res.status   <= enq ? sbmq_pkg::ST_FULL : sbmq_pkg::ST_EMPTY;
            r_res.data_out <= '0;
        end else if (i_cmd.finish) begin
            r_res.status   <= sbmq_pkg::ST_OK;
            r_res.data_out <= (r_op == sbmq_pkg::REQ_ENQ) ? 32'sd0 : signed'(dout_ext[31:0]);
        end
    end

    `ASSERT_ALWAYS(a_free_ends, i_clk, i_rst_n,
        (r_free_head < NULL_LINK) == (r_free_tail < NULL_LINK))
    `ASSERT_ALWAYS(a_queue_ends, i_clk, i_rst_n,
        (r_qhead[0] < NULL_LINK) == (r_qtail[0] < NULL_LINK))
    `ASSERT_IMPL(a_clear_done, i_clk, i_rst_n,
        $past(i_cmd.clear && o_stat.clear_last), r_free_head == '0)

endmodule

// File: design/sbmq_ctrl.sv
// controller state machine of the shared buffer multi queue
module sbmq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  sbmq_pkg::t_stat i_stat,
    output sbmq_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_done
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_done;

    assign o_cmd.clear  = (r_state == S_CLEAR);
    assign o_cmd.accept = (r_state == S_IDLE) && i_start && i_stat.ok;
    assign o_cmd.fail   = (r_state == S_IDLE) && i_start && !i_stat.ok;
    assign o_cmd.finish = (r_state == S_EXEC);
    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_done <= o_cmd.fail || o_cmd.finish;
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.clear_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd.accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/shared_buffer_multi_queue_unit.sv
// top level of the shared buffer multi queue
// result: for an accepted request the strobe follows the execute state and the done register;
// for one that reports full or empty it comes in the cycle after the request
// issue: a new request is taken only once the previous one has left the execute state, as the
// link memory read at accept is followed by the tail link write; full or empty requests never leave idle
// reset: busy stays high while the link memory is chained slot by slot
// results cannot be stalled: each is shown for one cycle with o_done
module shared_buffer_multi_queue_unit #(
    parameter int SLOT_COUNT  = 16,
    parameter int QUEUE_COUNT = 4,
    parameter int DATA_WIDTH  = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  sbmq_pkg::t_req  i_req,
    output logic            o_done,
    output sbmq_pkg::t_res  o_res
);

    sbmq_pkg::t_cmd  cmd;
    sbmq_pkg::t_stat stat;

    sbmq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    sbmq_datapath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .QUEUE_COUNT (QUEUE_COUNT),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res)
    );

endmodule

// File: tb/sv/tb_shared_buffer_multi_queue_unit.sv
// testbench for the shared buffer multi queue: random and directed queue ops against a shadow model
`timescale 1ns / 1ps

module tb_shared_buffer_multi_queue_unit;
    import sbmq_pkg::*;

    localparam int SLOTS       = 16;
    localparam int QUEUES      = 4;
    localparam int NIL         = SLOTS;
    localparam int RAND_ITEMS  = 1900;
    localparam int CHUNK       = 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_req req;
        int   gap;
        bit   drain;
    } t_queued_req;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    t_queued_req req_backlog[$];
    t_res        awaited_results[$];

    int link_mem[SLOTS];
    logic [31:0] slot_val[SLOTS];
    int q_head[QUEUES];
    int q_tail[QUEUES];
    int fl_head;
    int fl_tail;

    int  n_total;
    int  n_issued;
    int  n_errors;
    int  cycle_count;
    int  gap_left;
    bit  gap_taken;
    t_queued_req cur;

    shared_buffer_multi_queue_unit #(
        .SLOT_COUNT(SLOTS),
        .QUEUE_COUNT(QUEUES),
        .DATA_WIDTH(32)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_res  (o_res)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int link_of(int s);
        return (link_mem[s] < SLOTS) ? link_mem[s] : NIL;
    endfunction

    function automatic t_res predict_queue_op(t_req r);
        t_res res;
        int   q;
        int   s;
        res = '0;
        q = int'(r.queue_id);
        if (q >= QUEUES) begin
            res.status = (r.req_type == REQ_DEQ) ? ST_EMPTY : ST_FULL;
        end else if (r.req_type == REQ_ENQ) begin
            s = fl_head;
            if (s >= SLOTS) begin
                res.status = ST_FULL;
            end else begin
                fl_head = link_of(s);
                if (fl_head >= SLOTS) fl_tail = NIL;
                slot_val[s] = r.data_in;
                link_mem[s] = NIL;
                if (q_head[q] < SLOTS && q_tail[q] < SLOTS) begin
                    link_mem[q_tail[q]] = s;
                    q_tail[q] = s;
                end else begin
                    q_head[q] = s;
                    q_tail[q] = s;
                end
                res.status = ST_OK;
            end
        end else begin
            s = q_head[q];
            if (s >= SLOTS) begin
                res.status = ST_EMPTY;
            end else begin
                res.data_out = slot_val[s];
                if (s == q_tail[q]) begin
                    q_head[q] = NIL;
                    q_tail[q] = NIL;
                end else begin
                    q_head[q] = link_of(s);
                    if (q_head[q] >= SLOTS) q_tail[q] = NIL;
                end
                link_mem[s] = NIL;
                if (fl_head < SLOTS && fl_tail < SLOTS) begin
                    link_mem[fl_tail] = s;
                    fl_tail = s;
                end else begin
                    fl_head = s;
                    fl_tail = s;
                end
                res.status = ST_OK;
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        n_errors++;
        $display("mismatch in %s: got %h, expected %h", what, got, want);
    endtask

    task automatic add_req(input logic kind, input logic [1:0] q, input logic [31:0] d,
                           input int gap, input bit drain);
        t_queued_req item;
        item.req.req_type = kind;
        item.req.queue_id = q;
        item.req.data_in  = d;
        item.gap   = gap;
        item.drain = drain;
        req_backlog.push_back(item);
    endtask

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            gap_left  = 0;
            gap_taken = 1'b0;
        end else begin
            if (start && !busy) begin
                awaited_results.push_back(predict_queue_op(i_req));
                n_issued++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (req_backlog.size() > 0 &&
                             (!req_backlog[0].drain || awaited_results.size() == 0)) begin
                    if (!gap_taken && req_backlog[0].gap > 0) begin
                        gap_left  = req_backlog[0].gap - 1;
                        gap_taken = 1'b1;
                        start <= 1'b0;
                    end else begin
                        cur = req_backlog.pop_front();
                        gap_taken = 1'b0;
                        i_req <= cur.req;
                        start <= 1'b1;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch("result with none awaited", {30'd0, o_res.status}, '0);
            end else begin
                t_res want;
                want = awaited_results.pop_front();
                if (o_res.status !== want.status)
                    flag_mismatch("status", {30'd0, o_res.status}, {30'd0, want.status});
                if (o_res.data_out !== want.data_out)
                    flag_mismatch("data_out", o_res.data_out, want.data_out);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int  enq_pct;
        int  focus;
        bit  quiet;
        logic [1:0] q;
        n_errors    = 0;
        n_issued    = 0;
        cycle_count = 0;
        for (int i = 0; i < SLOTS; i++) begin
            link_mem[i] = i + 1;
            slot_val[i] = '0;
        end
        for (int i = 0; i < QUEUES; i++) begin
            q_head[i] = NIL;
            q_tail[i] = NIL;
        end
        fl_head = 0;
        fl_tail = SLOTS - 1;

        // empty dequeue, extreme values, last element out
        add_req(REQ_DEQ, 2'd2, 32'h1234_5678, 0, 1'b0);
        add_req(REQ_ENQ, 2'd0, 32'h7fff_ffff, 0, 1'b0);
        add_req(REQ_ENQ, 2'd1, 32'h8000_0000, 1, 1'b0);
        add_req(REQ_DEQ, 2'd1, 32'hffff_ffff, 0, 1'b0);
        add_req(REQ_DEQ, 2'd0, 32'h0000_0000, 0, 1'b0);
        // drain the free list, then hit full
        for (int i = 0; i < SLOTS; i++)
            add_req(REQ_ENQ, 2'(i), (i % 2) ? 32'hffff_ffff : 32'h0000_0000, 0, 1'b0);
        add_req(REQ_ENQ, 2'd3, 32'h5a5a_a5a5, 0, 1'b0);
        // freed slot becomes both ends of the free list, then gets reused
        add_req(REQ_DEQ, 2'd2, 32'h0000_0000, 0, 1'b0);
        add_req(REQ_ENQ, 2'd1, 32'hdead_beef, 0, 1'b0);

        for (int c = 0; c < RAND_ITEMS / CHUNK; c++) begin
            case ($urandom_range(2))
                0: enq_pct = 15;
                1: enq_pct = 50;
                default: enq_pct = 85;
            endcase
            focus = ($urandom_range(1) == 0) ? $urandom_range(QUEUES - 1) : -1;
            quiet = (c % 5 == 0);
            for (int k = 0; k < CHUNK; k++) begin
                q = (focus >= 0) ? 2'(focus) : 2'($urandom_range(QUEUES - 1));
                add_req(($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ, q, pick_data(),
                        pick_gap(quiet), (k == 0) && (c % 10 == 0));
            end
        end
        n_total = req_backlog.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_issued < n_total) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
